[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types for the rational arithmetic unit
// Opcodes, sequencer states and the word structs.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_GCD_CHK,
    ST_GCD_WAIT,
    ST_QN_WAIT,
    ST_QD_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        zero_den_error;
  } out_t;

endpackage

[rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add, subtract, multiply, divide
// Cross products through one shared multiplier, Euclid GCD and the final
// reductions through one shared bit-serial divider.
// ----------------------------------------------------------------------------
// sequence: three products and the sum, a divider pass per euclid step, then
//   the two reductions and the result register; the strobe cycle follows,
//   and a 0/0 word skips the divider
// throughput: one word at a time, busy high from accept until the strobe
// the divider loop sets how long a word takes; the result strobe cannot be stalled
// reset clears the sequencer and the strobe; data registers are not reset
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op_i,
  input  logic [WORD_BITS-1:0] a_num_i,
  input  logic [WORD_BITS-1:0] a_den_i,
  input  logic [WORD_BITS-1:0] b_num_i,
  input  logic [WORD_BITS-1:0] b_den_i,
  output logic                done_o,
  output logic [WORD_BITS-1:0] res_num_o,
  output logic [WORD_BITS-1:0] res_den_o,
  output logic                zero_den_error_o
);

  localparam int W = WORD_BITS;

  rau_pkg::state_e  state_q, state_d;
  rau_pkg::op_e     op_q, op_d;
  logic         div_start, div_done;
  logic [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0] p_q, p_d, s_q, s_d;
  logic [W-1:0] x_q, x_d, y_q, y_d;
  logic [W-1:0] num_q, num_d, den_q, den_d;
  logic [W-1:0] qn_q, qn_d;
  logic [W-1:0] rn_q, rn_d, rd_q, rd_d;
  logic         err_q, err_d, done_q, done_d;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic [W-1:0] div_a, div_b, div_quo, div_rem;

  // shared multiplier, low word only
  assign mul_p = W'(mul_a * mul_b);

  rau_div #(.W(W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (div_a),
    .b_i    (div_b),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    an_q  <= an_d;
    ad_q  <= ad_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    p_q   <= p_d;
    s_q   <= s_d;
    x_q   <= x_d;
    y_q   <= y_d;
    num_q <= num_d;
    den_q <= den_d;
    qn_q  <= qn_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    err_q <= err_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    p_d = p_q; s_d = s_q; x_d = x_q; y_d = y_q;
    num_d = num_q; den_d = den_q; qn_d = qn_q;
    rn_d = rn_q; rd_d = rd_q; err_d = err_q;
    done_d = 1'b0;
    div_start = 1'b0;
    div_a = x_q;
    div_b = y_q;
    mul_a = an_q;
    mul_b = bd_q;
    unique case (state_q)
      rau_pkg::ST_IDLE: begin
        if (start) begin
          op_d = rau_pkg::op_e'(op_i);
          // zero denominator makes the fraction 0/1
          an_d = (a_den_i == '0) ? '0 : a_num_i;
          ad_d = (a_den_i == '0) ? W'(1) : a_den_i;
          bn_d = (b_den_i == '0) ? '0 : b_num_i;
          bd_d = (b_den_i == '0) ? W'(1) : b_den_i;
          state_d = rau_pkg::ST_MUL0;
        end
      end
      rau_pkg::ST_MUL0: begin
        // first numerator product
        mul_a = an_q;
        mul_b = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
        p_d = mul_p;
        state_d = rau_pkg::ST_MUL1;
      end
      rau_pkg::ST_MUL1: begin
        // second product: ad*bn
        mul_a = ad_q;
        mul_b = bn_q;
        s_d = mul_p;
        state_d = rau_pkg::ST_MUL2;
      end
      rau_pkg::ST_MUL2: begin
        // denominator: ad*bd, or for divide the earlier ad*bn product
        mul_a = ad_q;
        mul_b = bd_q;
        den_d = (op_q == rau_pkg::OP_DIV) ? s_q : mul_p;
        state_d = rau_pkg::ST_SUM;
      end
      rau_pkg::ST_SUM: begin
        unique case (op_q)
          rau_pkg::OP_ADD: num_d = p_q + s_q;
          rau_pkg::OP_SUB: num_d = p_q - s_q;
          default:         num_d = p_q;
        endcase
        state_d = rau_pkg::ST_MUL3;
      end
      rau_pkg::ST_MUL3: begin
        x_d = num_q;
        y_d = den_q;
        state_d = rau_pkg::ST_GCD_CHK;
      end
      rau_pkg::ST_GCD_CHK: begin
        if (y_q == '0) begin
          if (x_q == '0) begin
            rn_d = '0; rd_d = W'(1); err_d = 1'b1;
            state_d = rau_pkg::ST_DONE;
          end else begin
            div_a = num_q;
            div_b = x_q;
            div_start = 1'b1;
            state_d = rau_pkg::ST_QN_WAIT;
          end
        end else begin
          div_start = 1'b1;
          state_d = rau_pkg::ST_GCD_WAIT;
        end
      end
      rau_pkg::ST_GCD_WAIT: begin
        if (div_done) begin
          x_d = y_q;
          y_d = div_rem;
          state_d = rau_pkg::ST_GCD_CHK;
        end
      end
      rau_pkg::ST_QN_WAIT: begin
        if (div_done) begin
          qn_d = div_quo;
          div_a = den_q;
          div_b = x_q;
          div_start = 1'b1;
          state_d = rau_pkg::ST_QD_WAIT;
        end
      end
      rau_pkg::ST_QD_WAIT: begin
        if (div_done) begin
          if (div_quo == '0) begin
            rn_d = '0; rd_d = W'(1); err_d = 1'b1;
          end else begin
            rn_d = qn_q; rd_d = div_quo; err_d = 1'b0;
          end
          state_d = rau_pkg::ST_DONE;
        end
      end
      rau_pkg::ST_DONE: begin
        done_d = 1'b1;
        state_d = rau_pkg::ST_IDLE;
      end
      default: state_d = rau_pkg::ST_IDLE;
    endcase
  end

  assign busy             = (state_q != rau_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign res_num_o        = rn_q;
  assign res_den_o        = rd_q;
  assign zero_den_error_o = err_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == rau_pkg::ST_IDLE) else $error("result outside idle");
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && err_q) |-> (rn_q == '0 && rd_q == W'(1)))
    else $error("error result not 0/1");
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rd_q != '0) else $error("zero denominator delivered");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == rau_pkg::ST_MUL0) else $error("start lost");

endmodule

[rtl/rau_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div: truncating signed divider
// Restoring division, one quotient bit a cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  q_q, q_d;
  logic [W:0]    r_q, r_d;
  logic [W-1:0]  d_q, d_d;
  logic          qneg_q, qneg_d, rneg_q, rneg_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic [W:0]    shifted;
  logic [W-1:0]  abs_a, abs_b;

  assign abs_a = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign abs_b = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  assign shifted = {r_q[W-1:0], q_q[W-1]};
  assign trial = shifted - {1'b0, d_q};

  // one restoring step per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      q_d    = abs_a;
      r_d    = '0;
      d_d    = abs_b;
      qneg_d = a_i[W-1] ^ b_i[W-1];
      rneg_d = a_i[W-1];
    end else if (busy_q) begin
      if (trial[W]) begin
        r_d = shifted;
        q_d = {q_q[W-2:0], 1'b0};
      end else begin
        r_d = trial;
        q_d = {q_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    r_q    <= r_d;
    d_q    <= d_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o = done_q;
  assign quo_o  = qneg_q ? (~q_q + 1'b1) : q_q;
  assign rem_o  = rneg_q ? (~r_q[W-1:0] + 1'b1) : r_q[W-1:0];

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done not a pulse");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("divider count not zero when idle");

endmodule

[dv/rau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker: result predictor and scoreboard for the rational unit
// Watches accepted command words and result strobes, works out each reduced
// fraction and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module rau_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  rau_pkg::in_t  cmd_i,
  input  logic          done_i,
  input  rau_pkg::out_t res_i,
  output int            fail_count_o,
  output int            pending_o
);

  localparam int MAX_REPORTS = 10;

  rau_pkg::out_t fraction_q[$];
  int            mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = fraction_q.size();

  // magnitude of a two's complement word, as unsigned
  function automatic logic [31:0] mag(logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  // truncating quotient, sign from both operands
  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    q = mag(a) / mag(b);
    return (a[31] ^ b[31]) ? (32'd0 - q) : q;
  endfunction

  // truncating remainder, sign of the dividend
  function automatic logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    r = mag(a) % mag(b);
    return a[31] ? (32'd0 - r) : r;
  endfunction

  function automatic rau_pkg::out_t reduce_fraction(rau_pkg::in_t c);
    logic [31:0]   an, ad, bn, bd, num, den, x, y, t, qn, qd;
    rau_pkg::out_t r;
    an = c.a_num; ad = c.a_den; bn = c.b_num; bd = c.b_den;
    // a zero denominator makes that fraction 0/1
    if (ad == 32'd0) begin an = 32'd0; ad = 32'd1; end
    if (bd == 32'd0) begin bn = 32'd0; bd = 32'd1; end
    case (rau_pkg::op_e'(c.op))
      rau_pkg::OP_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
      rau_pkg::OP_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
      rau_pkg::OP_MUL: begin num = an * bn;           den = ad * bd; end
      default: begin num = an * bd;                   den = ad * bn; end
    endcase
    // euclid with truncating remainder
    x = num; y = den;
    while (y != 32'd0) begin
      t = trunc_rem(x, y);
      x = y;
      y = t;
    end
    r.res_num = 32'd0;
    r.res_den = 32'd1;
    r.zero_den_error = 1'b1;
    if (x != 32'd0) begin
      qn = trunc_div(num, x);
      qd = trunc_div(den, x);
      if (qd != 32'd0) begin
        r.res_num = qn;
        r.res_den = qd;
        r.zero_den_error = 1'b0;
      end
    end
    return r;
  endfunction

  // capture accepted words and check strobed results
  always @(posedge clk_i) begin
    rau_pkg::out_t e;
    if (rst_ni) begin
      if (start_i && !busy_i) fraction_q.push_back(reduce_fraction(cmd_i));
      if (done_i) begin
        if (fraction_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word num=%h den=%h err=%b",
                     res_i.res_num, res_i.res_den, res_i.zero_den_error);
        end else begin
          e = fraction_q.pop_front();
          if (e.res_num !== res_i.res_num || e.res_den !== res_i.res_den ||
              e.zero_den_error !== res_i.zero_den_error) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected %h/%h err=%b, got %h/%h err=%b",
                       e.res_num, e.res_den, e.zero_den_error,
                       res_i.res_num, res_i.res_den, res_i.zero_den_error);
          end
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the rational arithmetic unit
// Directed corner words then bursty random words; a separate checker
// predicts and scores every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  RANDOM_ITEMS = 600;
  localparam int  DRAIN_CYCLES = 2000;
  localparam longint CYCLE_LIMIT = 64'd8000000;

  logic clk_i, rst_ni, start, busy, done_o;
  rau_pkg::in_t  cmd;
  rau_pkg::out_t res;
  int   fail_count, pending;
  longint cycles = 0;
  int   burst_left;

  rational_arithmetic_unit #(.WORD_BITS(32)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(cmd.op), .a_num_i(cmd.a_num), .a_den_i(cmd.a_den),
    .b_num_i(cmd.b_num), .b_den_i(cmd.b_den), .done_o(done_o),
    .res_num_o(res.res_num), .res_den_o(res.res_den),
    .zero_den_error_o(res.zero_den_error)
  );

  rau_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .cmd_i(cmd), .done_i(done_o), .res_i(res),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit test failed");
      $finish;
    end
  end

  // drive one word and hold it until accepted, then maybe open a gap
  task automatic send_word(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    start     <= 1'b1;
    cmd.op    <= op;
    cmd.a_num <= an;
    cmd.a_den <= ad;
    cmd.b_num <= bn;
    cmd.b_den <= bd;
    do @(posedge clk_i); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // operand pick: mostly small or special values, some full-width
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return $urandom_range(0, 2000) - 1000;
      3: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'd0;
          4: return 32'h0001_0000;
          default: return 32'd1;
        endcase
      end
      4: return $urandom_range(0, 65535) - 32768;
      default: return $urandom & 32'h00ff_ffff;
    endcase
  endfunction

  initial begin
    logic [31:0] ad, bd;
    int i;
    burst_left = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd        = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each op, extremes, zero denominators, wrap cases
    send_word(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(rau_pkg::OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4);
    send_word(rau_pkg::OP_DIV, 32'd2, 32'd3, 32'd3, 32'd4);
    send_word(rau_pkg::OP_ADD, 32'd5, 32'd0, 32'd7, 32'd0);
    send_word(rau_pkg::OP_DIV, 32'd0, 32'd5, 32'd0, 32'd7);
    send_word(rau_pkg::OP_DIV, 32'd3, 32'd5, 32'd0, 32'd7);
    send_word(rau_pkg::OP_MUL, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
    send_word(rau_pkg::OP_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    send_word(rau_pkg::OP_MUL, 32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000);
    send_word(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_word(rau_pkg::OP_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
    send_word(rau_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    send_word(rau_pkg::OP_SUB, 32'd3, 32'hffff_fffa, 32'd1, 32'd4);
    send_word(rau_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff);
    send_word(rau_pkg::OP_DIV, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff);
    send_word(rau_pkg::OP_SUB, 32'd4, 32'd6, 32'd2, 32'd3);
    send_word(rau_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    send_word(rau_pkg::OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0);

    // hold off until every directed result is back
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // random words
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      ad = pick_value();
      bd = pick_value();
      if ($urandom_range(0, 15) == 0) ad = 32'd0;
      if ($urandom_range(0, 15) == 0) bd = 32'd0;
      send_word(2'($urandom_range(0, 3)), pick_value(), ad, pick_value(), bd);
    end
    start <= 1'b0;
    @(posedge clk_i);

    // drain
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("rational_arithmetic_unit test passed");
    end else begin
      $display("rational_arithmetic_unit test failed");
    end
    $finish;
  end

endmodule
